// ----- sv/csr_pkg.sv -----
// Shared types and constants for the cubic sample reader.
// Used by the top level; no dependencies.
package csr_pkg;

  // Track geometry, fixed by the field widths of the item and register ports
  localparam int MAX_FRAMES = 4096;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int MEM_WORDS  = 2 * MAX_FRAMES;
  localparam int MEM_ADDR_W = $clog2(MEM_WORDS);

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int OUT_W      = 17;
  localparam int FRAC_W     = 16;
  localparam int FRAMES_W   = 13;
  localparam int CHAN_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // Default fraction resolution of the read position
  localparam int DEF_FRACTION_BITS = 16;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_LOADED = 1'b1;

  // Channel codes
  localparam logic [CHAN_W-1:0] CHAN_MONO   = 2'd1;
  localparam logic [CHAN_W-1:0] CHAN_STEREO = 2'd2;

  // Read issue sequencer
  typedef enum logic {
    SEQ_FREE,
    SEQ_ISSUE
  } seq_state_e;

  // Per-channel tag carried down the interpolation pipeline
  typedef struct packed {
    logic last;     // final channel of an item: emit the result
    logic mono;     // copy this channel to both outputs
    logic no_data;  // empty track: emit zeros with the flag
  } lane_tag_t;

endpackage

// ----- sv/csr_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module csr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, or read into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/cubic_sample_reader.sv -----
// Catmull-Rom cubic resampler over a 16-bit PCM track held in a sample RAM.
// Depends on csr_pkg and csr_ram.
//
// A write item (kind 0) stores one sample word. A read item (kind 1)
// fetches the four neighbouring frames, clamped to the track ends, from
// the single-port sample RAM: 4 reads for mono, 8 for stereo, one RAM
// read per cycle; read 0 goes out with the transfer and busy stays high
// while the rest are issued. A read with no frames loaded issues no RAM
// read. The next item is accepted as soon as the RAM port is free; the
// interpolation runs in a separate 7-stage pipeline with three multipliers,
// so its work overlaps the next item's reads. done is high for exactly one
// cycle per read item; the results must be taken in that cycle since there
// is no back-pressure.
// Results keep the order of the read items.
module cubic_sample_reader #(
  parameter int FRACTION_BITS = csr_pkg::DEF_FRACTION_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Item transfer
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    kind_i,
  input  logic [csr_pkg::MEM_ADDR_W-1:0]          word_address_i,
  input  logic signed [csr_pkg::SAMPLE_W-1:0]     sample_value_i,
  input  logic [csr_pkg::FRAME_W-1:0]             position_whole_i,
  input  logic [csr_pkg::FRAC_W-1:0]              position_fraction_i,
  // Results
  output logic                                    done_o,
  output logic signed [csr_pkg::OUT_W-1:0]        left_sample_o,
  output logic signed [csr_pkg::OUT_W-1:0]        right_sample_o,
  output logic                                    no_data_o,
  // Register writes
  input  logic                                    cfg_we_i,
  input  logic [csr_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [csr_pkg::CFG_DATA_W-1:0]          cfg_data_i
);
  import csr_pkg::*;

  // Fraction handling
  localparam int FBITS = (FRACTION_BITS < FRAC_W) ? FRACTION_BITS : FRAC_W;
  localparam logic [FRAC_W-1:0] FRAC_MASK = FRAC_W'((64'd1 << FBITS) - 64'd1);
  localparam int FS_W = FRAC_W + 1;

  // Datapath widths
  localparam int SUM_W = SAMPLE_W + 5;
  localparam int A_W   = SAMPLE_W + 3;
  localparam int B_W   = SAMPLE_W + 4;
  localparam int C_W   = SAMPLE_W + 1;
  localparam int M1_W  = A_W + FS_W;
  localparam int U1_W  = SAMPLE_W + 5;
  localparam int M2_W  = U1_W + FS_W;
  localparam int U2_W  = SAMPLE_W + 5;
  localparam int M3_W  = U2_W + FS_W;
  localparam int P1_SH_W = FRACTION_BITS + SAMPLE_W + 1;
  localparam int U3_W  = ((P1_SH_W > M3_W) ? P1_SH_W : M3_W) + 2;
  localparam int Q_W   = U3_W - FRACTION_BITS - 1;

  localparam logic signed [U3_W-1:0] ROUND_HALF = U3_W'(64'd1 << FRACTION_BITS);
  localparam logic signed [Q_W-1:0]  SAT_HI     = Q_W'(65535);
  localparam logic signed [Q_W-1:0]  SAT_LO     = Q_W'(-65536);

  localparam logic [2:0] LAST_READ_MONO   = 3'd3;
  localparam logic [2:0] LAST_READ_STEREO = 3'd7;
  localparam logic [1:0] LAST_TAP         = 2'd3;

  function automatic logic [MEM_ADDR_W-1:0] frame_word(input logic [FRAME_W-1:0] idx,
                                                       input logic ch,
                                                       input logic mono);
    if (mono) begin
      frame_word = {1'b0, idx};
    end else begin
      frame_word = {idx, ch};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [CHAN_W-1:0]   channel_count_q;
  logic [FRAMES_W-1:0] frames_loaded_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= CHAN_STEREO;
      frames_loaded_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[CHAN_W-1:0];
        CFG_FRAMES_LOADED: frames_loaded_q <= cfg_data_i[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Tap index clamping for the incoming read item
  // ---------------------------------------------------------------------------
  logic [FRAMES_W-1:0] frames_eff;
  logic                has_data;
  logic [FRAME_W-1:0]  last_frame;
  logic [FRAME_W-1:0]  idx0_c, idx1_c, idx2_c, idx3_c;
  logic                mono_c;

  always_comb begin
    frames_eff = (frames_loaded_q > FRAMES_W'(MAX_FRAMES)) ? FRAMES_W'(MAX_FRAMES)
                                                           : frames_loaded_q;
    has_data   = (frames_eff != '0);
    last_frame = FRAME_W'(frames_eff - FRAMES_W'(1));
    idx1_c     = (position_whole_i > last_frame) ? last_frame : position_whole_i;
    idx0_c     = (idx1_c != '0) ? idx1_c - FRAME_W'(1) : '0;
    idx2_c     = (idx1_c < last_frame) ? idx1_c + FRAME_W'(1) : last_frame;
    idx3_c     = (idx2_c < last_frame) ? idx2_c + FRAME_W'(1) : last_frame;
    mono_c     = (channel_count_q == CHAN_MONO);
  end

  // ---------------------------------------------------------------------------
  // Item transfer decode
  // ---------------------------------------------------------------------------
  seq_state_e seq_q, seq_d;
  logic accept, acc_write, acc_fetch, acc_empty;

  assign busy      = (seq_q == SEQ_ISSUE);
  assign accept    = start & ~busy;
  assign acc_write = accept & (kind_i == KIND_WRITE);
  assign acc_fetch = accept & (kind_i == KIND_READ) & has_data;
  assign acc_empty = accept & (kind_i == KIND_READ) & ~has_data;

  // Item context held while its reads are issued
  logic [FRAME_W-1:0] idx_q [4];
  logic [FRAC_W-1:0]  f_q;
  logic               mono_q;
  logic [2:0]         rd_last_q;
  logic [2:0]         rd_cnt_q, rd_cnt_d;

  always_ff @(posedge clk_i) begin
    if (acc_fetch) begin
      idx_q[0]  <= idx0_c;
      idx_q[1]  <= idx1_c;
      idx_q[2]  <= idx2_c;
      idx_q[3]  <= idx3_c;
      f_q       <= position_fraction_i & FRAC_MASK;
      mono_q    <= mono_c;
      rd_last_q <= mono_c ? LAST_READ_MONO : LAST_READ_STEREO;
    end
  end

  // ---------------------------------------------------------------------------
  // Read issue sequencer: read 0 goes out with the transfer, the rest follow
  // ---------------------------------------------------------------------------
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_FREE:  if (acc_fetch) seq_d = SEQ_ISSUE;
      SEQ_ISSUE: if (rd_cnt_q == rd_last_q) seq_d = SEQ_FREE;
      default:   seq_d = SEQ_FREE;
    endcase
  end

  logic                  mem_en, mem_we;
  logic [MEM_ADDR_W-1:0] mem_addr;
  logic                  issue_valid;
  logic [2:0]            issue_cnt;

  always_comb begin
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = word_address_i;
    issue_valid = 1'b0;
    issue_cnt   = '0;
    rd_cnt_d    = rd_cnt_q;
    unique case (seq_q)
      SEQ_FREE: begin
        if (acc_write) begin
          mem_en = 1'b1;
          mem_we = 1'b1;
        end else if (acc_fetch) begin
          mem_en      = 1'b1;
          mem_addr    = frame_word(idx0_c, 1'b0, mono_c);
          issue_valid = 1'b1;
          rd_cnt_d    = 3'd1;
        end
      end
      SEQ_ISSUE: begin
        mem_en      = 1'b1;
        mem_addr    = frame_word(idx_q[rd_cnt_q[1:0]], rd_cnt_q[2], mono_q);
        issue_valid = 1'b1;
        issue_cnt   = rd_cnt_q;
        rd_cnt_d    = rd_cnt_q + 3'd1;
      end
      default: ;
    endcase
  end

  logic       cap_valid_q;
  logic [2:0] cap_cnt_q;
  logic       nd_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_FREE;
      rd_cnt_q    <= '0;
      cap_valid_q <= 1'b0;
      cap_cnt_q   <= '0;
      nd_pend_q   <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      rd_cnt_q    <= rd_cnt_d;
      cap_valid_q <= issue_valid;
      cap_cnt_q   <= issue_cnt;
      nd_pend_q   <= acc_empty;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample RAM
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] mem_rdata;

  csr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_WORDS)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (sample_value_i),
    .rdata_o (mem_rdata)
  );

  // Collect taps; the fourth tap is used straight from the RAM output
  logic signed [SAMPLE_W-1:0] tap_q [4];

  always_ff @(posedge clk_i) begin
    if (cap_valid_q) begin
      tap_q[cap_cnt_q[1:0]] <= $signed(mem_rdata);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline feed: one channel per entry
  // ---------------------------------------------------------------------------
  logic                       feed_valid;
  lane_tag_t                  feed_tag;
  logic signed [SAMPLE_W-1:0] fp0, fp1, fp2, fp3;
  logic signed [SUM_W-1:0]    e0, e1, e2, e3, a_sum, b_sum, c_sum;

  always_comb begin
    feed_valid       = (cap_valid_q && (cap_cnt_q[1:0] == LAST_TAP)) || nd_pend_q;
    feed_tag.last    = nd_pend_q | mono_q | cap_cnt_q[2];
    feed_tag.mono    = mono_q;
    feed_tag.no_data = nd_pend_q;
    if (nd_pend_q) begin
      fp0 = '0;
      fp1 = '0;
      fp2 = '0;
      fp3 = '0;
    end else begin
      fp0 = tap_q[0];
      fp1 = tap_q[1];
      fp2 = tap_q[2];
      fp3 = $signed(mem_rdata);
    end
    e0 = SUM_W'(fp0);
    e1 = SUM_W'(fp1);
    e2 = SUM_W'(fp2);
    e3 = SUM_W'(fp3);
    // A = -p0 + 3p1 - 3p2 + p3, B = 2p0 - 5p1 + 4p2 - p3, C = p2 - p0
    a_sum = (e3 - e0) + ((e1 - e2) <<< 1) + (e1 - e2);
    b_sum = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    c_sum = e2 - e0;
  end

  // ---------------------------------------------------------------------------
  // Interpolation pipeline (Horner form, three multiplies)
  // ---------------------------------------------------------------------------
  logic [7:1] st_valid_q;

  logic signed [A_W-1:0]      st1_a_q;
  logic signed [B_W-1:0]      st1_b_q, st2_b_q;
  logic signed [C_W-1:0]      st1_c_q, st2_c_q, st3_c_q, st4_c_q;
  logic signed [SAMPLE_W-1:0] st1_p1_q, st2_p1_q, st3_p1_q, st4_p1_q, st5_p1_q, st6_p1_q;
  logic [FRAC_W-1:0]          st1_f_q, st2_f_q, st3_f_q, st4_f_q, st5_f_q;
  lane_tag_t                  st1_tag_q, st2_tag_q, st3_tag_q, st4_tag_q, st5_tag_q;
  lane_tag_t                  st6_tag_q, st7_tag_q;
  logic signed [M1_W-1:0]     st2_m1_q;
  logic signed [U1_W-1:0]     st3_u1_q;
  logic signed [M2_W-1:0]     st4_m2_q;
  logic signed [U2_W-1:0]     st5_u2_q;
  logic signed [M3_W-1:0]     st6_m3_q;
  logic signed [U3_W-1:0]     st7_u3_q;

  logic signed [FS_W-1:0]     fs1, fs3, fs5;
  logic signed [M1_W-1:0]     m1_c;
  logic signed [U1_W-1:0]     u1_c;
  logic signed [M2_W-1:0]     m2_c;
  logic signed [U2_W-1:0]     u2_c;
  logic signed [M3_W-1:0]     m3_c;
  logic signed [U3_W-1:0]     u3_c;
  logic signed [Q_W-1:0]      q_c;
  logic signed [OUT_W-1:0]    sat_c;

  always_comb begin
    fs1   = $signed({1'b0, st1_f_q});
    fs3   = $signed({1'b0, st3_f_q});
    fs5   = $signed({1'b0, st5_f_q});
    m1_c  = st1_a_q * fs1;
    u1_c  = U1_W'(st2_m1_q >>> FRACTION_BITS) + U1_W'(st2_b_q);
    m2_c  = st3_u1_q * fs3;
    u2_c  = U2_W'(st4_m2_q >>> FRACTION_BITS) + U2_W'(st4_c_q);
    m3_c  = st5_u2_q * fs5;
    // Low bits of the shifted p1 term are zero, so the rounding half is ORed in
    u3_c  = U3_W'(st6_m3_q) + ((U3_W'(st6_p1_q) <<< (FRACTION_BITS + 1)) | ROUND_HALF);
    q_c   = Q_W'(st7_u3_q >>> (FRACTION_BITS + 1));
    if (q_c > SAT_HI) begin
      sat_c = OUT_W'(SAT_HI);
    end else if (q_c < SAT_LO) begin
      sat_c = OUT_W'(SAT_LO);
    end else begin
      sat_c = OUT_W'(q_c);
    end
  end

  // Advance the pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= '0;
    end else begin
      st_valid_q <= {st_valid_q[6:1], feed_valid};
    end
  end

  // Advance the pipeline payload
  always_ff @(posedge clk_i) begin
    st1_a_q   <= A_W'(a_sum);
    st1_b_q   <= B_W'(b_sum);
    st1_c_q   <= C_W'(c_sum);
    st1_p1_q  <= fp1;
    st1_f_q   <= f_q;
    st1_tag_q <= feed_tag;

    st2_m1_q  <= m1_c;
    st2_b_q   <= st1_b_q;
    st2_c_q   <= st1_c_q;
    st2_p1_q  <= st1_p1_q;
    st2_f_q   <= st1_f_q;
    st2_tag_q <= st1_tag_q;

    st3_u1_q  <= u1_c;
    st3_c_q   <= st2_c_q;
    st3_p1_q  <= st2_p1_q;
    st3_f_q   <= st2_f_q;
    st3_tag_q <= st2_tag_q;

    st4_m2_q  <= m2_c;
    st4_c_q   <= st3_c_q;
    st4_p1_q  <= st3_p1_q;
    st4_f_q   <= st3_f_q;
    st4_tag_q <= st3_tag_q;

    st5_u2_q  <= u2_c;
    st5_p1_q  <= st4_p1_q;
    st5_f_q   <= st4_f_q;
    st5_tag_q <= st4_tag_q;

    st6_m3_q  <= m3_c;
    st6_p1_q  <= st5_p1_q;
    st6_tag_q <= st5_tag_q;

    st7_u3_q  <= u3_c;
    st7_tag_q <= st6_tag_q;
  end

  // ---------------------------------------------------------------------------
  // Result register: hold left until right arrives, or copy mono to both
  // ---------------------------------------------------------------------------
  logic                    done_q;
  logic signed [OUT_W-1:0] left_hold_q, left_q, right_q;
  logic                    no_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= st_valid_q[7] & st7_tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_valid_q[7]) begin
      if (!st7_tag_q.last) begin
        left_hold_q <= sat_c;
      end else if (st7_tag_q.no_data) begin
        left_q    <= '0;
        right_q   <= '0;
        no_data_q <= 1'b1;
      end else begin
        left_q    <= st7_tag_q.mono ? sat_c : left_hold_q;
        right_q   <= sat_c;
        no_data_q <= 1'b0;
      end
    end
  end

  assign done_o         = done_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;
  assign no_data_o      = no_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_issue_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_ISSUE) |-> (rd_cnt_q != 3'd0) && (rd_cnt_q <= rd_last_q))
    else $error("read issue count out of range");

  a_feed_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nd_pend_q |-> !(cap_valid_q && (cap_cnt_q[1:0] == LAST_TAP)))
    else $error("empty-track entry collides with a tap feed");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(st_valid_q[7] && st7_tag_q.last))
    else $error("result strobe without a final pipeline entry");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for cubic_sample_reader: directed script, then random phases.
// Depends on csr_pkg and the cubic_sample_reader RTL; nothing else is read at run time.
`timescale 1ns / 100ps

module testbench;
  import csr_pkg::*;

  localparam int  STALL_LIMIT  = 2000;   // cycles with no activity before giving up
  localparam int  DRAIN_CYCLES = 20;     // settle time before a register write
  localparam int  END_CYCLES   = 30;     // quiet time after the last result
  localparam longint FRAC_ONE  = longint'(1) << DEF_FRACTION_BITS;

  // Channel codes outside the named pair; both act as stereo
  localparam logic [CHAN_W-1:0] CHAN_ODD_ZERO  = 2'd0;
  localparam logic [CHAN_W-1:0] CHAN_ODD_THREE = 2'd3;

  typedef struct packed {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
    logic                    no_data;
  } frame_result_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_READ,
    ROW_CFG
  } row_op_e;

  // One line of the directed script; register rows reuse addr/value as index/data
  typedef struct packed {
    row_op_e                 op;
    logic [MEM_ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0]     value;
    logic [FRAME_W-1:0]      whole;
    logic [FRAC_W-1:0]       frac;
    logic                    typed;
    frame_result_t           want;
  } script_row_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic [FRAMES_W-1:0] frames;
    logic [9:0]          budget;
  } run_phase_t;

  localparam frame_result_t R_NONE   = '0;
  localparam frame_result_t R_EMPTY  = '{17'sd0, 17'sd0, 1'b1};
  localparam frame_result_t R_EDGES  = '{-17'sd32768, 17'sd32767, 1'b0};
  localparam frame_result_t R_MONO_0 = '{17'sd32767, 17'sd32767, 1'b0};

  localparam script_row_t SCRIPT [28] = '{
    // empty track after reset
    '{ROW_READ,  13'd0,    16'h0000, 12'd0,    16'h0000, 1'b1, R_EMPTY},
    '{ROW_READ,  13'd0,    16'h0000, 12'd4095, 16'hFFFF, 1'b1, R_EMPTY},
    // one stereo frame at full scale: every tap is the same frame
    '{ROW_CFG,   CFG_FRAMES_LOADED, 16'd1, 12'd0, 16'h0000, 1'b0, R_NONE},
    '{ROW_WRITE, 13'd0,    16'h8000, 12'd0,    16'h0000, 1'b0, R_NONE},
    '{ROW_WRITE, 13'd1,    16'h7FFF, 12'd0,    16'h0000, 1'b0, R_NONE},
    '{ROW_READ,  13'd0,    16'h0000, 12'd0,    16'h0000, 1'b1, R_EDGES},
    '{ROW_READ,  13'd0,    16'h0000, 12'd4095, 16'hFFFF, 1'b1, R_EDGES},
    // four mono frames swinging between the rails
    '{ROW_CFG,   CFG_CHANNEL_COUNT, CHAN_MONO, 12'd0, 16'h0000, 1'b0, R_NONE},
    '{ROW_CFG,   CFG_FRAMES_LOADED, 16'd4, 12'd0, 16'h0000, 1'b0, R_NONE},
    '{ROW_WRITE, 13'd0,    16'h7FFF, 12'd0,    16'h0000, 1'b0, R_NONE},
    '{ROW_WRITE, 13'd1,    16'h8000, 12'd0,    16'h0000, 1'b0, R_NONE},
    '{ROW_WRITE, 13'd2,    16'h7FFF, 12'd0,    16'h0000, 1'b0, R_NONE},
    '{ROW_WRITE, 13'd3,    16'h8000, 12'd0,    16'h0000, 1'b0, R_NONE},
    '{ROW_READ,  13'd0,    16'h0000, 12'd0,    16'h0000, 1'b1, R_MONO_0},
    '{ROW_READ,  13'd0,    16'h0000, 12'd1,    16'h8000, 1'b0, R_NONE},
    '{ROW_READ,  13'd0,    16'h0000, 12'd2,    16'h0001, 1'b0, R_NONE},
    '{ROW_READ,  13'd0,    16'h0000, 12'd3,    16'hFFFF, 1'b0, R_NONE},
    '{ROW_READ,  13'd0,    16'h0000, 12'd4095, 16'h1234, 1'b0, R_NONE},
    // odd channel code, frame count past the memory: top of the track
    '{ROW_CFG,   CFG_CHANNEL_COUNT, CHAN_ODD_ZERO, 12'd0, 16'h0000, 1'b0, R_NONE},
    '{ROW_CFG,   CFG_FRAMES_LOADED, 16'd8191, 12'd0, 16'h0000, 1'b0, R_NONE},
    '{ROW_WRITE, 13'd8186, 16'h1234, 12'd0,    16'h0000, 1'b0, R_NONE},
    '{ROW_WRITE, 13'd8187, 16'hEDCB, 12'd0,    16'h0000, 1'b0, R_NONE},
    '{ROW_WRITE, 13'd8188, 16'h8000, 12'd0,    16'h0000, 1'b0, R_NONE},
    '{ROW_WRITE, 13'd8189, 16'h7FFF, 12'd0,    16'h0000, 1'b0, R_NONE},
    '{ROW_WRITE, 13'd8190, 16'h0001, 12'd0,    16'h0000, 1'b0, R_NONE},
    '{ROW_WRITE, 13'd8191, 16'hFFFF, 12'd0,    16'h0000, 1'b0, R_NONE},
    '{ROW_READ,  13'd0,    16'h0000, 12'd4095, 16'hC000, 1'b0, R_NONE},
    '{ROW_READ,  13'd0,    16'h0000, 12'd4094, 16'h4000, 1'b0, R_NONE}
  };

  localparam run_phase_t PLAN [10] = '{
    '{CHAN_MONO,      13'd1,    10'd50},
    '{CHAN_STEREO,    13'd2,    10'd60},
    '{CHAN_ODD_THREE, 13'd4096, 10'd110},
    '{CHAN_MONO,      13'd8191, 10'd80},
    '{CHAN_ODD_ZERO,  13'd5,    10'd60},
    '{CHAN_STEREO,    13'd0,    10'd30},
    '{CHAN_MONO,      13'd37,   10'd80},
    '{CHAN_STEREO,    13'd300,  10'd120},
    '{CHAN_STEREO,    13'd3,    10'd60},
    '{CHAN_MONO,      13'd4,    10'd60}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic                          kind_i;
  logic [MEM_ADDR_W-1:0]         word_address_i;
  logic signed [SAMPLE_W-1:0]    sample_value_i;
  logic [FRAME_W-1:0]            position_whole_i;
  logic [FRAC_W-1:0]             position_fraction_i;
  logic                          done_o;
  logic signed [OUT_W-1:0]       left_sample_o;
  logic signed [OUT_W-1:0]       right_sample_o;
  logic                          no_data_o;
  logic                          cfg_we_i;
  logic [CFG_IDX_W-1:0]          cfg_index_i;
  logic [CFG_DATA_W-1:0]         cfg_data_i;

  // Shadow of the block: sample words, which words hold data, and the registers
  logic signed [SAMPLE_W-1:0]    track_words [MEM_WORDS];
  bit                            word_loaded [MEM_WORDS];
  logic [CHAN_W-1:0]             chan_cfg;
  logic [FRAMES_W-1:0]           frames_cfg;

  frame_result_t                 pending_frames [$];
  bit                            burst_mode;
  int                            error_count;
  int                            item_count;
  int                            reads_sent;
  int                            writes_sent;
  int                            reg_writes;
  int                            results_seen;
  int                            empty_results;
  int                            stall_cycles;

  cubic_sample_reader dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic int track_frames();
    return (frames_cfg > MAX_FRAMES) ? MAX_FRAMES : int'(frames_cfg);
  endfunction

  // Clamp the four neighbouring frames to the track ends
  function automatic void frame_taps(input int whole, output int taps[4]);
    int last;
    last    = track_frames() - 1;
    taps[1] = (whole > last) ? last : whole;
    taps[0] = (taps[1] > 0) ? taps[1] - 1 : 0;
    taps[2] = (taps[1] < last) ? taps[1] + 1 : last;
    taps[3] = (taps[2] < last) ? taps[2] + 1 : last;
  endfunction

  function automatic int tap_word(input int frame, input int ch);
    return (chan_cfg == CHAN_MONO) ? frame : 2 * frame + ch;
  endfunction

  // Cubic in fixed point; arithmetic shifts floor, the last step rounds half up
  function automatic logic signed [OUT_W-1:0] catmull_rom(input longint p0, p1, p2, p3, f);
    longint a, b, c, u;
    a = -p0 + 3 * p1 - 3 * p2 + p3;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c = p2 - p0;
    u = (a * f + b * FRAC_ONE) >>> DEF_FRACTION_BITS;
    u = (u * f + c * FRAC_ONE) >>> DEF_FRACTION_BITS;
    u = u * f + 2 * p1 * FRAC_ONE;
    u = (u + FRAC_ONE) >>> (DEF_FRACTION_BITS + 1);
    if (u > 65535) u = 65535;
    if (u < -65536) u = -65536;
    return u[OUT_W-1:0];
  endfunction

  function automatic frame_result_t predict_frame(input logic [FRAME_W-1:0] whole,
                                                  input logic [FRAC_W-1:0] frac);
    frame_result_t res;
    int taps[4];
    logic signed [OUT_W-1:0] level;
    res = '0;
    if (track_frames() == 0) begin
      res.no_data = 1'b1;
      return res;
    end
    frame_taps(int'(whole), taps);
    // mono maps both channels onto the same words
    for (int ch = 0; ch < 2; ch++) begin
      level = catmull_rom(longint'(track_words[tap_word(taps[0], ch)]),
                          longint'(track_words[tap_word(taps[1], ch)]),
                          longint'(track_words[tap_word(taps[2], ch)]),
                          longint'(track_words[tap_word(taps[3], ch)]),
                          longint'(frac));
      if (ch == 0) res.left = level;
      else res.right = level;
    end
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pcm_word();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Present one item after a random gap, hold it until the transfer, then update the shadow
  task automatic send_item(input logic kind, input logic [MEM_ADDR_W-1:0] addr,
                           input logic [SAMPLE_W-1:0] value, input logic [FRAME_W-1:0] whole,
                           input logic [FRAC_W-1:0] frac, input logic typed,
                           input frame_result_t typed_res);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) burst_mode = !burst_mode;
    gap = burst_mode ? 0 : $urandom_range(0, 14);
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start               <= 1'b1;
    kind_i              <= kind;
    word_address_i      <= addr;
    sample_value_i      <= value;
    position_whole_i    <= whole;
    position_fraction_i <= frac;
    do @(posedge clk_i); while (busy !== 1'b0);
    item_count++;
    if (kind == KIND_WRITE) begin
      track_words[addr] = value;
      word_loaded[addr] = 1'b1;
      writes_sent++;
    end else begin
      pending_frames.push_back(typed ? typed_res : predict_frame(whole, frac));
      reads_sent++;
    end
  endtask

  // Write a register once the block has gone quiet
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == CFG_CHANNEL_COUNT) chan_cfg = data[CHAN_W-1:0];
    else frames_cfg = data;
    reg_writes++;
  endtask

  // Mostly reads whose taps get loaded first; the rest are stray writes anywhere
  task automatic random_item();
    int frames, whole, pick;
    int taps[4];
    int word;
    logic [FRAC_W-1:0] frac;
    if ($urandom_range(0, 99) < 15) begin
      send_item(KIND_WRITE, MEM_ADDR_W'($urandom_range(0, MEM_WORDS - 1)), pcm_word(),
                FRAME_W'($urandom_range(0, 4095)), FRAC_W'($urandom_range(0, 65535)),
                1'b0, R_NONE);
      return;
    end
    frames = track_frames();
    pick   = $urandom_range(0, 7);
    if (frames == 0 || pick == 2) whole = $urandom_range(0, 4095);
    else if (pick == 0) whole = 0;
    else if (pick == 1) whole = frames - 1;
    else whole = $urandom_range(0, frames - 1);
    case ($urandom_range(0, 7))
      0: frac = '0;
      1: frac = '1;
      default: frac = FRAC_W'($urandom_range(0, 65535));
    endcase
    if (frames != 0) begin
      frame_taps(whole, taps);
      foreach (taps[k]) begin
        for (int ch = 0; ch < 2; ch++) begin
          word = tap_word(taps[k], ch);
          if (!word_loaded[word])
            send_item(KIND_WRITE, MEM_ADDR_W'(word), pcm_word(),
                      FRAME_W'($urandom_range(0, 4095)), FRAC_W'($urandom_range(0, 65535)),
                      1'b0, R_NONE);
        end
      end
    end
    send_item(KIND_READ, MEM_ADDR_W'($urandom_range(0, MEM_WORDS - 1)),
              SAMPLE_W'($urandom_range(0, 65535)), FRAME_W'(whole), frac, 1'b0, R_NONE);
  endtask

  // Compare each result with the oldest outstanding read
  always @(posedge clk_i) begin : check_results
    frame_result_t got, want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      got = '{left_sample_o, right_sample_o, no_data_o};
      results_seen++;
      if (got.no_data === 1'b1) empty_results++;
      if (pending_frames.size() == 0) begin
        report_mismatch("result with no read outstanding, left_sample", got.left, 0);
      end else begin
        want = pending_frames.pop_front();
        if (got.left !== want.left) report_mismatch("left_sample", got.left, want.left);
        if (got.right !== want.right) report_mismatch("right_sample", got.right, want.right);
        if (got.no_data !== want.no_data)
          report_mismatch("no_data", got.no_data, want.no_data);
      end
    end
  end

  // Stop a hung run: any transfer, result or register write resets the count
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1 || cfg_we_i || !rst_ni)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d reads outstanding",
               STALL_LIMIT, pending_frames.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int target;
    rst_ni              = 1'b0;
    start               = 1'b0;
    kind_i              = KIND_WRITE;
    word_address_i      = '0;
    sample_value_i      = '0;
    position_whole_i    = '0;
    position_fraction_i = '0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = CFG_CHANNEL_COUNT;
    cfg_data_i          = '0;
    chan_cfg            = CHAN_STEREO;
    frames_cfg          = '0;
    burst_mode          = 1'b0;
    error_count         = 0;
    item_count          = 0;
    reads_sent          = 0;
    writes_sent         = 0;
    reg_writes          = 0;
    results_seen        = 0;
    empty_results       = 0;
    stall_cycles        = 0;
    foreach (word_loaded[i]) word_loaded[i] = 1'b0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed script
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].op == ROW_CFG)
        write_register(SCRIPT[i].addr[CFG_IDX_W-1:0], SCRIPT[i].value[CFG_DATA_W-1:0]);
      else
        send_item((SCRIPT[i].op == ROW_READ) ? KIND_READ : KIND_WRITE, SCRIPT[i].addr,
                  SCRIPT[i].value, SCRIPT[i].whole, SCRIPT[i].frac, SCRIPT[i].typed,
                  SCRIPT[i].want);
    end

    // Random phases, each under its own track shape
    foreach (PLAN[p]) begin
      write_register(CFG_CHANNEL_COUNT, PLAN[p].chan);
      write_register(CFG_FRAMES_LOADED, PLAN[p].frames);
      target = item_count + int'(PLAN[p].budget);
      while (item_count < target) random_item();
    end

    // Drain and let the pipeline settle
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);

    $display("Run covered %0d frame reads and %0d sample writes over %0d register writes;",
             reads_sent, writes_sent, reg_writes);
    $display("%0d results compared, %0d of them from an empty track, %0d mismatches",
             results_seen, empty_results, error_count);
    if (error_count == 0 && pending_frames.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/csr_pkg.sv
sv/csr_ram.sv
sv/cubic_sample_reader.sv
tb/testbench.sv
